// ----- hw/rtl/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the text section extractor: result and
// bundle records, parse state encodings, character codes and the key table.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam logic [3:0] KEY_LEN = 4'd8;
    localparam logic [3:0] CNT_MAX = 4'd15;
    localparam logic [3:0] HDR_MIN = 4'd2;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_SECTION = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        TK_BEFORE  = 4'b0001,
        TK_IN      = 4'b0010,
        TK_TRAIL   = 4'b0100,
        TK_SPOILED = 4'b1000
    } tok_phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       header_seen;
        logic       cr_pending;
        tok_phase_t token_phase;
        logic       comment_seen;
        logic [3:0] token_count;
        logic       first_is_open;
        logic       last_is_close;
        logic       name_matches;
        logic       line_open;
    } pstate_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       line_end;
        logic       drop_line;
        logic       done_res;
        logic       found;
    } res_t;

    // up to three results caused by one input byte
    typedef struct packed {
        res_t [2:0] res;
        logic [1:0] cnt;
    } bundle_t;

    // "[script]" in lower case
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] ch;
        begin
            unique case (idx)
                3'd0:    ch = CH_OPEN;
                3'd1:    ch = 8'h73;
                3'd2:    ch = 8'h63;
                3'd3:    ch = 8'h72;
                3'd4:    ch = 8'h69;
                3'd5:    ch = 8'h70;
                3'd6:    ch = 8'h74;
                default: ch = CH_CLOSE;
            endcase
            return ch;
        end
    endfunction

    function automatic logic [7:0] low_case(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
            return r;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ----- hw/rtl/tse_front.sv -----
// ----------------------------------------------------------------------------
// tse_front
// Accepts text bytes, tracks the line key and section phase, and turns each
// byte into a bundle of zero to three results for the result queue.
// ----------------------------------------------------------------------------
module tse_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    input  logic             start_text,
    input  logic             q_full,
    output logic             push,
    output tse_pkg::bundle_t push_data
);
    import tse_pkg::*;

    typedef struct packed {
        pstate_t s;
        res_t    r;
        logic    v;
    } close_t;

    localparam pstate_t ST_CLEAR = '{
        phase:         PH_SEARCH,
        header_seen:   1'b0,
        cr_pending:    1'b0,
        token_phase:   TK_BEFORE,
        comment_seen:  1'b0,
        token_count:   4'd0,
        first_is_open: 1'b0,
        last_is_close: 1'b0,
        name_matches:  1'b1,
        line_open:     1'b0
    };

    function automatic pstate_t clear_line(input pstate_t s);
        pstate_t t;
        begin
            t = ST_CLEAR;
            t.phase = s.phase;
            t.header_seen = s.header_seen;
            return t;
        end
    endfunction

    function automatic pstate_t track_key(input pstate_t s, input logic [7:0] c);
        pstate_t t;
        begin
            t = s;
            if (!s.comment_seen) begin
                if (c == CH_SEMI) begin
                    t.comment_seen = 1'b1;
                end else if (is_space(c)) begin
                    if (s.token_phase == TK_IN) t.token_phase = TK_TRAIL;
                end else begin
                    if (s.token_phase == TK_BEFORE) begin
                        t.token_phase = TK_IN;
                        t.first_is_open = (c == CH_OPEN);
                    end else if (s.token_phase == TK_TRAIL) begin
                        t.token_phase = TK_SPOILED;
                        t.name_matches = 1'b0;
                    end
                    if (s.token_count < KEY_LEN) begin
                        if (low_case(c) != key_char(s.token_count[2:0]))
                            t.name_matches = 1'b0;
                    end else begin
                        t.name_matches = 1'b0;
                    end
                    if (s.token_count < CNT_MAX) t.token_count = s.token_count + 4'd1;
                    t.last_is_close = (c == CH_CLOSE);
                end
            end
            return t;
        end
    endfunction

    function automatic close_t close_line(input pstate_t s, input logic fin);
        close_t o;
        logic   clean;
        begin
            o   = '0;
            o.s = s;
            clean = (s.token_phase == TK_IN) || (s.token_phase == TK_TRAIL);
            if (s.phase == PH_SEARCH) begin
                if (clean && s.token_count == KEY_LEN && s.name_matches) begin
                    o.s.phase = PH_SECTION;
                    o.s.header_seen = 1'b1;
                end
                if (fin) begin
                    o.r.done_res = 1'b1;
                    o.r.found = o.s.header_seen;
                    o.v = 1'b1;
                    o.s.phase = PH_DONE;
                end
            end else begin
                o.v = 1'b1;
                if (clean && s.token_count >= HDR_MIN && s.first_is_open
                    && s.last_is_close) begin
                    o.r.line_end  = 1'b1;
                    o.r.drop_line = 1'b1;
                    o.r.done_res  = 1'b1;
                    o.r.found     = 1'b1;
                    o.s.phase     = PH_DONE;
                end else begin
                    o.r.out_byte = CH_LF;
                    o.r.has_byte = 1'b1;
                    o.r.line_end = 1'b1;
                    o.r.done_res = fin;
                    o.r.found    = fin;
                    if (fin) o.s.phase = PH_DONE;
                end
            end
            o.s = clear_line(o.s);
            return o;
        end
    endfunction

    pstate_t state_reg, state_next;
    bundle_t bnd;
    logic    in_fire;

    assign in_ready  = !q_full;
    assign in_fire   = in_valid && in_ready;
    assign push      = in_fire && (bnd.cnt != 2'd0);
    assign push_data = bnd;

    always_comb
    begin
        pstate_t s;
        close_t  cl;
        res_t    r;
        s  = state_reg;
        cl = '0;
        r  = '0;
        bnd = '0;
        if (start_text) s = ST_CLEAR;
        if (s.phase == PH_SEARCH || s.phase == PH_SECTION) begin
            if (in_byte == CH_NUL) begin
                if (s.line_open) begin
                    cl = close_line(s, 1'b1);
                    s  = cl.s;
                    if (cl.v) begin
                        bnd.res[bnd.cnt] = cl.r;
                        bnd.cnt = bnd.cnt + 2'd1;
                    end
                end else begin
                    r = '0;
                    r.done_res = 1'b1;
                    r.found = s.header_seen;
                    bnd.res[bnd.cnt] = r;
                    bnd.cnt = bnd.cnt + 2'd1;
                    s.phase = PH_DONE;
                end
            end else if (in_byte == CH_LF) begin
                cl = close_line(s, end_of_text);
                s  = cl.s;
                if (cl.v) begin
                    bnd.res[bnd.cnt] = cl.r;
                    bnd.cnt = bnd.cnt + 2'd1;
                end
            end else begin
                if (s.phase == PH_SECTION) begin
                    // held-back cr goes out ahead of the byte that follows it
                    if (s.cr_pending) begin
                        r = '0;
                        r.out_byte = CH_CR;
                        r.has_byte = 1'b1;
                        bnd.res[bnd.cnt] = r;
                        bnd.cnt = bnd.cnt + 2'd1;
                    end
                    if (in_byte == CH_CR) begin
                        s.cr_pending = 1'b1;
                    end else begin
                        s.cr_pending = 1'b0;
                        r = '0;
                        r.out_byte = in_byte;
                        r.has_byte = 1'b1;
                        bnd.res[bnd.cnt] = r;
                        bnd.cnt = bnd.cnt + 2'd1;
                    end
                end
                s = track_key(s, in_byte);
                s.line_open = 1'b1;
                if (end_of_text) begin
                    cl = close_line(s, 1'b1);
                    s  = cl.s;
                    if (cl.v) begin
                        bnd.res[bnd.cnt] = cl.r;
                        bnd.cnt = bnd.cnt + 2'd1;
                    end
                end
            end
        end
        state_next = in_fire ? s : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // after the section ends nothing is produced until new text starts
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !start_text && state_reg.phase == PH_DONE) |-> !push)
        else $error("result produced after section end");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE && !(in_fire && start_text))
        |=> state_reg.phase == PH_DONE)
        else $error("left done phase without start of text");

    a_key_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.token_count == CNT_MAX && in_fire && !start_text && in_byte != CH_LF
         && in_byte != CH_NUL && !end_of_text)
        |=> (state_reg.token_count == CNT_MAX || state_reg.phase == PH_DONE))
        else $error("key length counter wrapped");

endmodule

// ----- hw/rtl/tse_queue.sv -----
// ----------------------------------------------------------------------------
// tse_queue
// Small fifo of result bundles between the parser front and the output back.
// ----------------------------------------------------------------------------
module tse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tse_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output tse_pkg::bundle_t q_data
);
    import tse_pkg::*;

    bundle_t        mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full    = (count_reg == QDEPTH[QAW:0]);
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("bundle queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QDEPTH[QAW:0])
        else $error("bundle queue count out of range");

endmodule

// ----- hw/rtl/tse_back.sv -----
// ----------------------------------------------------------------------------
// tse_back
// Holds one bundle in an output register and hands its results out one
// transfer at a time, marking the final result of each input byte.
// ----------------------------------------------------------------------------
module tse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tse_pkg::bundle_t q_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             has_byte,
    output logic             line_end,
    output logic             drop_line,
    output logic             done_res,
    output logic             found,
    output logic             last
);
    import tse_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_fire;
    logic       at_last;
    res_t       r;

    assign out_valid = cur_valid_reg;
    assign out_fire  = out_valid && out_ready;
    assign at_last   = (idx_reg == cur_reg.cnt - 2'd1);
    // next bundle loads in the same cycle the final result leaves
    assign pop       = q_valid && (!cur_valid_reg || (out_fire && at_last));

    assign r         = cur_reg.res[idx_reg];
    assign out_byte  = r.out_byte;
    assign has_byte  = r.has_byte;
    assign line_end  = r.line_end;
    assign drop_line = r.drop_line;
    assign done_res  = r.done_res;
    assign found     = r.found;
    assign last      = at_last;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end else if (out_fire && at_last) begin
            cur_valid_next = 1'b0;
        end else if (out_fire) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.cnt != 2'd0))
        else $error("empty bundle in output register");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < cur_reg.cnt))
        else $error("result index beyond bundle");

    a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !at_last) |=> (cur_valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("result skipped or repeated");

endmodule

// ----- hw/rtl/text_section_extractor_top.sv -----
// ----------------------------------------------------------------------------
// text_section_extractor_top
// Streams text bytes, finds the script section and passes its lines on
// byte by byte with a line verdict at each line end.
//
//   channel  handshake and fields
//   in       in_valid in_ready in_byte end_of_text start_text
//   out      out_valid out_ready out_byte has_byte line_end drop_line done_res found last
//
// one input byte is taken per cycle while the bundle queue has room;
// each byte yields zero to three results, sent one per cycle by the back end while out_ready is high
// a byte reaches the output through the bundle queue and then the output register
// the 4-entry bundle queue lets the input run on while the output stalls
// reset clears parse state and empties the queue and output register; no clearing pass
// ----------------------------------------------------------------------------
module text_section_extractor_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    input  logic       start_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       line_end,
    output logic       drop_line,
    output logic       done_res,
    output logic       found,
    output logic       last
);
    import tse_pkg::*;

    logic    push;
    bundle_t push_data;
    logic    q_full;
    logic    pop;
    logic    q_valid;
    bundle_t q_data;

    tse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .start_text  (start_text),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    tse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    tse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .line_end  (line_end),
        .drop_line (drop_line),
        .done_res  (done_res),
        .found     (found),
        .last      (last)
    );

endmodule

// ----- test/tb_text_section_extractor_top.sv -----
// ----------------------------------------------------------------------------
// tb_text_section_extractor_top
// Self-checking bench for the text section extractor. Texts are streamed in
// byte by byte, a behavioral copy of the line parser predicts every result,
// and each result transfer is compared field by field with the oldest
// prediction. Both channels idle and stall at random outside the steady-stream test.
// ----------------------------------------------------------------------------
module tb_text_section_extractor_top;

    import tse_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_PRINTS  = 40;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       line_end;
        logic       drop_line;
        logic       done_res;
        logic       found;
        logic       last;
    } script_res_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       end_of_text = 1'b0;
    logic       start_text  = 1'b0;
    logic       out_ready   = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       line_end;
    logic       drop_line;
    logic       done_res;
    logic       found;
    logic       last;

    // parser copy
    phase_t     sec_phase;
    logic       hdr_seen;
    logic       cr_hold;
    tok_phase_t key_phase;
    logic       in_comment;
    logic [3:0] key_len;
    logic       key_open;
    logic       key_close;
    logic       key_match;
    logic       line_busy;
    string      script_key = "[script]";

    script_res_t step_res[$];
    script_res_t pending_res[$];
    logic [7:0]  text_q[$];

    int  err_count    = 0;
    int  res_checked  = 0;
    int  bytes_sent   = 0;
    int  live_bytes   = 0;
    int  texts_sent   = 0;
    int  stall_cycles = 0;
    bit  calm         = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    text_section_extractor_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .start_text  (start_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .line_end    (line_end),
        .drop_line   (drop_line),
        .done_res    (done_res),
        .found       (found),
        .last        (last)
    );

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c | 8'h20;
        return c;
    endfunction

    function automatic void clear_line_state();
        cr_hold    = 1'b0;
        key_phase  = TK_BEFORE;
        in_comment = 1'b0;
        key_len    = 4'd0;
        key_open   = 1'b0;
        key_close  = 1'b0;
        key_match  = 1'b1;
        line_busy  = 1'b0;
    endfunction

    function automatic void clear_text_state();
        sec_phase = PH_SEARCH;
        hdr_seen  = 1'b0;
        clear_line_state();
    endfunction

    function automatic void add_res(input logic [7:0] b, input logic hb, input logic le,
                                    input logic dr, input logic dn, input logic fd);
        script_res_t r;
        r = '{out_byte: b, has_byte: hb, line_end: le, drop_line: dr,
              done_res: dn, found: fd, last: 1'b0};
        step_res.push_back(r);
    endfunction

    function automatic void scan_key(input logic [7:0] c);
        if (in_comment)
            return;
        if (c == CH_SEMI) begin
            in_comment = 1'b1;
            return;
        end
        if (blank_char(c)) begin
            if (key_phase == TK_IN)
                key_phase = TK_TRAIL;
            return;
        end
        if (key_phase == TK_BEFORE) begin
            key_phase = TK_IN;
            key_open  = (c == CH_OPEN);
        end else if (key_phase == TK_TRAIL) begin
            // a second word after blanks spoils the key
            key_phase = TK_SPOILED;
            key_match = 1'b0;
        end
        if (key_len < KEY_LEN) begin
            if (to_lower(c) != script_key[key_len])
                key_match = 1'b0;
        end else begin
            key_match = 1'b0;
        end
        if (key_len < CNT_MAX)
            key_len = key_len + 4'd1;
        key_close = (c == CH_CLOSE);
    endfunction

    function automatic void close_line(input logic at_end);
        logic clean;
        clean = (key_phase == TK_IN) || (key_phase == TK_TRAIL);
        if (sec_phase == PH_SEARCH) begin
            if (clean && key_len == KEY_LEN && key_match) begin
                sec_phase = PH_SECTION;
                hdr_seen  = 1'b1;
            end
            if (at_end) begin
                add_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, hdr_seen);
                sec_phase = PH_DONE;
            end
        end else if (clean && key_len >= HDR_MIN && key_open && key_close) begin
            // next bracketed header closes the section
            add_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
            sec_phase = PH_DONE;
        end else begin
            add_res(CH_LF, 1'b1, 1'b1, 1'b0, at_end, at_end);
            if (at_end)
                sec_phase = PH_DONE;
        end
        clear_line_state();
    endfunction

    // returns 1 when the byte was not ignored
    function automatic bit predict_byte(input logic [7:0] c, input logic eot,
                                        input logic st);
        script_res_t r;
        step_res.delete();
        if (st)
            clear_text_state();
        if (sec_phase != PH_SEARCH && sec_phase != PH_SECTION)
            return 1'b0;
        if (c == CH_NUL) begin
            if (line_busy) begin
                close_line(1'b1);
            end else begin
                add_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, hdr_seen);
                sec_phase = PH_DONE;
            end
        end else if (c == CH_LF) begin
            close_line(eot);
        end else begin
            if (sec_phase == PH_SECTION) begin
                // a held cr goes out only when the line continues
                if (cr_hold)
                    add_res(CH_CR, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
                cr_hold = (c == CH_CR);
                if (c != CH_CR)
                    add_res(c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            scan_key(c);
            line_busy = 1'b1;
            if (eot)
                close_line(1'b1);
        end
        for (int i = 0; i < step_res.size(); i++) begin
            r      = step_res[i];
            r.last = (i == step_res.size() - 1);
            pending_res.push_back(r);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     res_checked, what, got, want);
    endtask

    // result side: check each transfer, then pick the next ready value
    always @(posedge clk) begin
        script_res_t want;
        if (rst_n && out_valid && out_ready) begin
            res_checked++;
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected result, out_byte", out_byte, 0);
            end else begin
                want = pending_res.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_byte, want.out_byte);
                if (has_byte !== want.has_byte)
                    report_mismatch("has_byte", has_byte, want.has_byte);
                if (line_end !== want.line_end)
                    report_mismatch("line_end", line_end, want.line_end);
                if (drop_line !== want.drop_line)
                    report_mismatch("drop_line", drop_line, want.drop_line);
                if (done_res !== want.done_res)
                    report_mismatch("done_res", done_res, want.done_res);
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 36);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eot, input logic st);
        if (!calm && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= c;
        end_of_text <= eot;
        start_text  <= st;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        if (predict_byte(c, eot, st))
            live_bytes++;
    endtask

    task automatic send_text(input bit st_first, input bit eot_last);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], eot_last && (i == text_q.size() - 1), st_first && (i == 0));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_res.size() != 0);
    endtask

    function automatic void load_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range(8'h61, 8'h7A));
        if ($urandom_range(1))
            c = c - 8'd32;
        return c;
    endfunction

    function automatic void put_blanks(input int n);
        repeat (n) text_q.push_back(pick_blank());
    endfunction

    function automatic void put_line_end();
        if ($urandom_range(3) == 0)
            text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
    endfunction

    // any byte but nul and newline
    function automatic void put_junk(input int n);
        logic [7:0] c;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       c = pick_blank();
                1:       c = CH_SEMI;
                2:       c = CH_OPEN;
                3:       c = CH_CLOSE;
                4:       c = CH_CR;
                5:       c = 8'($urandom_range(8'h80, 8'hFF));
                6:       c = 8'($urandom_range(8'h01, 8'h1F));
                default: c = 8'($urandom_range(8'h21, 8'h7E));
            endcase
            if (c == CH_LF)
                c = 8'h0B;
            text_q.push_back(c);
        end
    endfunction

    function automatic void put_script_key();
        string word;
        word = "SCRIPT";
        put_blanks($urandom_range(0, 2));
        text_q.push_back(CH_OPEN);
        for (int i = 0; i < word.len(); i++)
            text_q.push_back($urandom_range(1) ? word[i] : to_lower(word[i]));
        text_q.push_back(CH_CLOSE);
        put_blanks($urandom_range(0, 2));
        if ($urandom_range(2) == 0) begin
            text_q.push_back(CH_SEMI);
            put_junk($urandom_range(0, 4));
        end
    endfunction

    function automatic void put_near_miss();
        case ($urandom_range(0, 5))
            0:       load_str("[SCRIPT");
            1:       load_str("[ScriptS]");
            2:       load_str("[SCR IPT]");
            3:       load_str("[script] x");
            4:       load_str(";[script]");
            default: load_str("[script][script]");
        endcase
    endfunction

    function automatic void put_section_header();
        put_blanks($urandom_range(0, 1));
        text_q.push_back(CH_OPEN);
        repeat ($urandom_range(0, 4)) text_q.push_back(pick_letter());
        text_q.push_back(CH_CLOSE);
        put_blanks($urandom_range(0, 1));
        if ($urandom_range(3) == 0) begin
            text_q.push_back(CH_SEMI);
            put_junk($urandom_range(0, 3));
        end
    endfunction

    // leading lines, usually the key line, section lines, then one way of ending
    task automatic run_script_text();
        int ending;
        text_q.delete();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(1))
                put_near_miss();
            else
                put_junk($urandom_range(0, 6));
            put_line_end();
        end
        if ($urandom_range(9) != 0) begin
            put_script_key();
            put_line_end();
        end
        repeat ($urandom_range(0, 4)) begin
            put_junk($urandom_range(0, 8));
            put_line_end();
        end
        ending = $urandom_range(0, 4);
        case (ending)
            0: begin
                put_section_header();
                put_line_end();
                put_junk($urandom_range(0, 2));
            end
            1:       put_junk($urandom_range(1, 5));
            3:       text_q.push_back(CH_NUL);
            default: ;
        endcase
        if (text_q.size() == 0)
            text_q.push_back(8'h78);
        send_text(1'b1, ending == 1 || ending == 2);
        texts_sent++;
    endtask

    task automatic test_directed();
        text_q.delete();
        load_str("[script]\n");
        send_text(1'b1, 1'b0);
        // inner cr pairs pass on, the cr before the newline is dropped
        text_q.delete();
        load_str("a\015\015b\015\n");
        send_text(1'b0, 1'b0);
        // cr held when the text ends is dropped
        text_q.delete();
        load_str("x\015");
        send_text(1'b0, 1'b1);
        send_byte(8'h71, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_script_texts(input int n);
        int goal;
        goal = live_bytes + n;
        while (live_bytes < goal)
            run_script_text();
    endtask

    task automatic test_steady_stream(input int n);
        int goal;
        goal = live_bytes + n;
        calm = 1'b1;
        while (live_bytes < goal)
            run_script_text();
        calm = 1'b0;
    endtask

    task automatic test_noise(input int n);
        int goal;
        logic [7:0] c;
        goal = live_bytes + n;
        while (live_bytes < goal) begin
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(9) == 0)
                c = CH_LF;
            send_byte(c, $urandom_range(19) == 0, $urandom_range(9) == 0);
        end
    endtask

    // sender holds off mid-line with a cr pending until all results are out
    task automatic test_drain_pause();
        text_q.delete();
        load_str("[Script]\nab\015");
        send_text(1'b1, 1'b0);
        wait_drained();
        text_q.delete();
        load_str("cd\n");
        send_text(1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);
    endtask

    initial begin
        clear_text_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_script_texts(90);
        test_steady_stream(45);
        test_noise(30);
        test_drain_pause();
        test_script_texts(75);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d generated texts plus directed and noise bytes", texts_sent);
        $display("%0d bytes sent (%0d parsed), %0d results checked, %0d mismatches",
                 bytes_sent, live_bytes, res_checked, err_count);
        if (err_count == 0 && pending_res.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- text_section_extractor_top.f -----
hw/rtl/tse_pkg.sv
hw/rtl/tse_front.sv
hw/rtl/tse_queue.sv
hw/rtl/tse_back.sv
hw/rtl/text_section_extractor_top.sv
test/tb_text_section_extractor_top.sv
